### design/put_pkg.sv
// ----------------------------------------------------------------------------
// Pending update table package
// Table size, operation and status codes, and small count helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package put_pkg;

	localparam int ENTRIES = 6;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = 3;

	localparam logic [2:0] OP_INSERT   = 3'd0;
	localparam logic [2:0] OP_CANCEL   = 3'd1;
	localparam logic [2:0] OP_LOOKUP   = 3'd2;
	localparam logic [2:0] OP_COMPLETE = 3'd3;
	localparam logic [2:0] OP_TICK     = 3'd4;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [1:0] STATUS_DUPLICATE = 2'd3;

	localparam logic [7:0] TYPE_NONE = 8'd0;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	function automatic cnt_t sat_inc(cnt_t v);
		return (v == '1) ? v : cnt_t'(v + 1'b1);
	endfunction

	function automatic cnt_t sat_dec(cnt_t v);
		return (v == '0) ? v : cnt_t'(v - 1'b1);
	endfunction

endpackage

`default_nettype wire

### design/pending_update_table_core.sv
// ----------------------------------------------------------------------------
// Pending update table core
// Six-entry table of pending updates keyed by device address, scanned one
// entry per cycle by a single address comparator under a small sequencer.
// ----------------------------------------------------------------------------
// An item is taken only when idle. The scan visits one entry per cycle, then the
// apply state applies the change and loads the result register; no new item is
// taken until the result is loaded or, after a tick, the last timeout is sent.
// A tick with timeouts then walks entries 0 to j, the last timed-out one, giving
// one result per timeout. A held result stalls the apply and emit states.
// Reset clears the sequencer, attempt counts and last acknowledged address.
`default_nettype none

module pending_update_table_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  operation,
	input  wire logic [63:0] dev_addr,
	input  wire logic [7:0]  new_attempts,
	input  wire logic [7:0]  new_type,
	input  wire logic [63:0] new_version,
	input  wire logic [15:0] new_checkin,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic             found,
	output logic [63:0]      addr_out,
	output logic [7:0]       type_out,
	output logic [63:0]      version_out,
	output logic [15:0]      checkin_out,
	output logic             timed_out,
	output logic [2:0]       pending_count,
	output logic [2:0]       noupdate_count,
	output logic             last
);
	import put_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_APPLY = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]  state_q;
	logic [2:0]  op_q;
	logic [63:0] addr_q;
	logic [7:0]  att_in_q;
	logic [7:0]  type_in_q;
	logic [63:0] ver_in_q;
	logic [15:0] chk_in_q;

	logic [63:0] ent_addr_q [ENTRIES];
	logic [7:0]  ent_att_q  [ENTRIES];
	logic [7:0]  ent_type_q [ENTRIES];
	logic [63:0] ent_ver_q  [ENTRIES];
	logic [15:0] ent_chk_q  [ENTRIES];
	logic [63:0] last_ack_q;

	idx_t        idx_q;
	idx_t        hit_idx_q;
	idx_t        free_idx_q;
	logic        hit_q;
	logic        free_q;
	logic [7:0]  hit_type_q;
	logic [63:0] hit_ver_q;
	logic [15:0] hit_chk_q;
	logic [ENTRIES-1:0] tmo_q;
	cnt_t        pend_q;
	cnt_t        noup_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic        found_q;
	logic [63:0] addr_out_q;
	logic [7:0]  type_out_q;
	logic [63:0] version_out_q;
	logic [15:0] checkin_out_q;
	logic        timed_out_q;
	cnt_t        pending_count_q;
	cnt_t        noupdate_count_q;
	logic        last_q;

	logic [63:0] cur_addr;
	logic [7:0]  cur_att;
	logic [7:0]  cur_type;
	logic [63:0] cur_ver;
	logic [15:0] cur_chk;
	logic [63:0] cmp_b;
	logic        addr_eq;
	logic        cur_live;
	logic        cur_match;
	logic        post_live;
	logic        scan_last;
	logic        out_free;
	logic        in_xfer;
	logic        go_emit;
	logic        apply_go;
	logic        out_load;
	logic [ENTRIES-1:0] rem_tmo;
	idx_t        sel_idx;

	logic [1:0]  res_status;
	logic        res_found;
	logic [63:0] res_addr;
	logic [7:0]  res_type;
	logic [63:0] res_ver;
	logic [15:0] res_chk;
	cnt_t        res_pend;
	cnt_t        res_noup;
	logic        ins_we;
	logic        free_we;
	logic        ack_we;
	logic [63:0] ack_val;

	assign cur_addr = ent_addr_q[idx_q];
	assign cur_att  = ent_att_q[idx_q];
	assign cur_type = ent_type_q[idx_q];
	assign cur_ver  = ent_ver_q[idx_q];
	assign cur_chk  = ent_chk_q[idx_q];

	// The one comparator serves the table scan and the duplicate check.
	assign cmp_b     = (state_q == ST_SCAN) ? cur_addr : last_ack_q;
	assign addr_eq   = (addr_q == cmp_b);
	assign cur_live  = (cur_att != 8'd0);
	assign cur_match = cur_live && addr_eq;
	assign scan_last = (idx_q == idx_t'(ENTRIES - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign go_emit   = (op_q == OP_TICK) && (tmo_q != '0);
	assign apply_go  = (state_q == ST_APPLY) && out_free && !go_emit;
	assign out_load  = apply_go || ((state_q == ST_EMIT) && tmo_q[idx_q] && out_free);
	assign rem_tmo   = tmo_q & ~({{(ENTRIES-1){1'b0}}, 1'b1} << idx_q);
	assign sel_idx   = hit_q ? hit_idx_q : free_idx_q;

	always_comb begin
		case (op_q)
			OP_CANCEL: post_live = cur_live && !addr_eq;
			OP_TICK:   post_live = (cur_att > 8'd1);
			default:   post_live = cur_live;
		endcase
	end

	always_comb begin
		res_status = STATUS_OK;
		res_found  = 1'b0;
		res_addr   = '0;
		res_type   = '0;
		res_ver    = '0;
		res_chk    = '0;
		res_pend   = pend_q;
		res_noup   = noup_q;
		ins_we     = 1'b0;
		free_we    = 1'b0;
		ack_we     = 1'b0;
		ack_val    = '0;
		unique case (op_q)
			OP_INSERT: begin
				if (hit_q || free_q) begin
					ins_we = 1'b1;
					if (hit_q) begin
						if (hit_type_q != TYPE_NONE) begin
							res_pend = sat_dec(res_pend);
						end else begin
							res_noup = sat_dec(res_noup);
						end
					end
					if (att_in_q != 8'd0) begin
						if (type_in_q != TYPE_NONE) begin
							res_pend = sat_inc(res_pend);
						end else begin
							res_noup = sat_inc(res_noup);
						end
					end
				end else begin
					res_status = STATUS_FULL;
				end
			end
			OP_LOOKUP: begin
				ack_we   = 1'b1;
				res_addr = addr_q;
				if (hit_q) begin
					res_found = 1'b1;
					res_type  = hit_type_q;
					res_ver   = hit_ver_q;
					res_chk   = hit_chk_q;
				end else begin
					res_status = STATUS_NOT_FOUND;
				end
			end
			OP_COMPLETE: begin
				if (addr_eq) begin
					res_status = STATUS_DUPLICATE;
				end else begin
					ack_we  = 1'b1;
					ack_val = addr_q;
					if (hit_q) begin
						free_we = 1'b1;
						if (hit_type_q != TYPE_NONE) begin
							res_pend = sat_dec(res_pend);
						end else begin
							res_noup = sat_dec(res_noup);
						end
					end else begin
						res_status = STATUS_NOT_FOUND;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			tmo_q       <= '0;
			pend_q      <= '0;
			noup_q      <= '0;
			out_valid_q <= 1'b0;
			last_ack_q  <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				ent_att_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SCAN;
						idx_q   <= '0;
						hit_q   <= 1'b0;
						free_q  <= 1'b0;
						tmo_q   <= '0;
						pend_q  <= '0;
						noup_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (cur_match && !hit_q) begin
						hit_q     <= 1'b1;
						hit_idx_q <= idx_q;
					end
					if (!cur_live && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_q;
					end
					if (post_live) begin
						if (cur_type != TYPE_NONE) begin
							pend_q <= sat_inc(pend_q);
						end else begin
							noup_q <= sat_inc(noup_q);
						end
					end
					if (op_q == OP_CANCEL && cur_match) begin
						ent_att_q[idx_q] <= '0;
					end
					if (op_q == OP_TICK) begin
						if (cur_att == 8'd1) begin
							ent_att_q[idx_q] <= '0;
							if (cur_type != TYPE_NONE) begin
								tmo_q[idx_q] <= 1'b1;
							end
						end else if (cur_att > 8'd1) begin
							ent_att_q[idx_q] <= cur_att - 8'd1;
						end
					end
					if (scan_last) begin
						state_q <= ST_APPLY;
						idx_q   <= '0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_APPLY: begin
					if (go_emit) begin
						state_q <= ST_EMIT;
					end else if (out_free) begin
						state_q     <= ST_IDLE;
						pend_q      <= res_pend;
						noup_q      <= res_noup;
						if (ins_we) begin
							ent_att_q[sel_idx] <= att_in_q;
						end
						if (free_we) begin
							ent_att_q[hit_idx_q] <= '0;
						end
						if (ack_we) begin
							last_ack_q <= ack_val;
						end
					end
				end
				ST_EMIT: begin
					if (tmo_q[idx_q]) begin
						if (out_free) begin
							tmo_q[idx_q] <= 1'b0;
							idx_q        <= idx_q + 1'b1;
							if (rem_tmo == '0) begin
								state_q <= ST_IDLE;
							end
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q      <= operation;
			addr_q    <= dev_addr;
			att_in_q  <= new_attempts;
			type_in_q <= new_type;
			ver_in_q  <= new_version;
			chk_in_q  <= new_checkin;
		end
		if (state_q == ST_SCAN) begin
			if (cur_match && !hit_q) begin
				hit_type_q <= cur_type;
				hit_ver_q  <= cur_ver;
				hit_chk_q  <= cur_chk;
			end
			if (op_q == OP_TICK && cur_att > 8'd1 && cur_chk != 16'd0) begin
				ent_chk_q[idx_q] <= cur_chk - 16'd1;
			end
		end
		if (apply_go) begin
			status_q         <= res_status;
			found_q          <= res_found;
			addr_out_q       <= res_addr;
			type_out_q       <= res_type;
			version_out_q    <= res_ver;
			checkin_out_q    <= res_chk;
			timed_out_q      <= 1'b0;
			pending_count_q  <= res_pend;
			noupdate_count_q <= res_noup;
			last_q           <= 1'b1;
			if (ins_we) begin
				ent_addr_q[sel_idx] <= addr_q;
				ent_type_q[sel_idx] <= type_in_q;
				ent_ver_q[sel_idx]  <= ver_in_q;
				ent_chk_q[sel_idx]  <= chk_in_q;
			end
		end
		if (state_q == ST_EMIT && tmo_q[idx_q] && out_free) begin
			status_q         <= STATUS_OK;
			found_q          <= 1'b0;
			addr_out_q       <= cur_addr;
			type_out_q       <= cur_type;
			version_out_q    <= cur_ver;
			checkin_out_q    <= cur_chk;
			timed_out_q      <= 1'b1;
			pending_count_q  <= pend_q;
			noupdate_count_q <= noup_q;
			last_q           <= (rem_tmo == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign found          = found_q;
	assign addr_out       = addr_out_q;
	assign type_out       = type_out_q;
	assign version_out    = version_out_q;
	assign checkin_out    = checkin_out_q;
	assign timed_out      = timed_out_q;
	assign pending_count  = pending_count_q;
	assign noupdate_count = noupdate_count_q;
	assign last           = last_q;

	// The emit walk only runs while some timed-out entry is still unreported.
	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (tmo_q != '0))
		else $error("emit walk without pending timeouts");

	// A timeout result always carries update data.
	a_timeout_type: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && timed_out) |-> (type_out != TYPE_NONE && status == STATUS_OK))
		else $error("timeout result without update data");

	// Live entry counts never exceed the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ({1'b0, pending_count} + {1'b0, noupdate_count} <= 4'(ENTRIES)))
		else $error("live entry counts exceed table size");

	// A lookup hit reports success and is the only result of its item.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && found) |-> (status == STATUS_OK && last && !timed_out))
		else $error("lookup hit with inconsistent result fields");

endmodule

`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pending update table testbench
// Sends insert, cancel, lookup, completion, tick and reserved operations,
// keeps a behavioral copy of the six-entry table to predict every result and
// checks each result transfer field by field, under sender and receiver idling
// and under a long result stall that backs up the input.
// ----------------------------------------------------------------------------
module tb;
	import put_pkg::*;

	localparam logic [2:0] OP_RESERVED_LO = 3'd5;
	localparam logic [2:0] OP_RESERVED_HI = 3'd7;
	localparam int POOL_SIZE = 9;
	localparam int TAIL_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [63:0] addr;
		logic [7:0]  dtype;
		logic [63:0] version;
		logic [15:0] checkin;
		logic        timed_out;
		logic [2:0]  pending;
		logic [2:0]  noupdate;
		logic        last;
	} reply_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  operation = OP_INSERT;
	logic [63:0] dev_addr = '0;
	logic [7:0]  new_attempts = '0;
	logic [7:0]  new_type = '0;
	logic [63:0] new_version = '0;
	logic [15:0] new_checkin = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic        found;
	logic [63:0] addr_out;
	logic [7:0]  type_out;
	logic [63:0] version_out;
	logic [15:0] checkin_out;
	logic        timed_out;
	logic [2:0]  pending_count;
	logic [2:0]  noupdate_count;
	logic        last;

	logic [63:0] tbl_addr     [ENTRIES];
	logic [7:0]  tbl_attempts [ENTRIES];
	logic [7:0]  tbl_type     [ENTRIES];
	logic [63:0] tbl_version  [ENTRIES];
	logic [15:0] tbl_checkin  [ENTRIES];
	logic [63:0] last_acked;

	reply_t      replies_due[$];
	logic [63:0] addr_pool [POOL_SIZE];

	int unsigned error_count = 0;
	int unsigned items_sent = 0;
	int unsigned replies_checked = 0;
	int unsigned timeouts_seen = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_token = 0;
	int unsigned hold_len = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;

	pending_update_table_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.dev_addr       (dev_addr),
		.new_attempts   (new_attempts),
		.new_type       (new_type),
		.new_version    (new_version),
		.new_checkin    (new_checkin),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.found          (found),
		.addr_out       (addr_out),
		.type_out       (type_out),
		.version_out    (version_out),
		.checkin_out    (checkin_out),
		.timed_out      (timed_out),
		.pending_count  (pending_count),
		.noupdate_count (noupdate_count),
		.last           (last)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int live_slot(input logic [63:0] a);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_attempts[i] != 8'd0 && tbl_addr[i] == a)
				return i;
		return -1;
	endfunction

	function automatic int free_slot();
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_attempts[i] == 8'd0)
				return i;
		return -1;
	endfunction

	task automatic apply_to_table(input logic [2:0] op, input logic [63:0] a,
			input logic [7:0] att, input logic [7:0] dt, input logic [63:0] ver,
			input logic [15:0] chk);
		reply_t r;
		reply_t made[$];
		int slot;
		int pend;
		int noup;
		r = '0;
		pend = 0;
		noup = 0;
		case (op)
			OP_INSERT: begin
				slot = live_slot(a);
				if (slot < 0)
					slot = free_slot();
				if (slot >= 0) begin
					tbl_addr[slot] = a;
					tbl_attempts[slot] = att;
					tbl_type[slot] = dt;
					tbl_version[slot] = ver;
					tbl_checkin[slot] = chk;
				end else begin
					r.status = STATUS_FULL;
				end
				made.push_back(r);
			end
			OP_CANCEL: begin
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_attempts[i] != 8'd0 && tbl_addr[i] == a)
						tbl_attempts[i] = 8'd0;
				made.push_back(r);
			end
			OP_LOOKUP: begin
				slot = live_slot(a);
				r.addr = a;
				if (slot >= 0) begin
					r.found = 1'b1;
					r.dtype = tbl_type[slot];
					r.version = tbl_version[slot];
					r.checkin = tbl_checkin[slot];
				end else begin
					r.status = STATUS_NOT_FOUND;
				end
				last_acked = '0;
				made.push_back(r);
			end
			OP_COMPLETE: begin
				if (a == last_acked) begin
					r.status = STATUS_DUPLICATE;
				end else begin
					last_acked = a;
					slot = live_slot(a);
					if (slot >= 0)
						tbl_attempts[slot] = 8'd0;
					else
						r.status = STATUS_NOT_FOUND;
				end
				made.push_back(r);
			end
			OP_TICK: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (tbl_attempts[i] == 8'd1) begin
						if (tbl_type[i] != TYPE_NONE) begin
							r = '0;
							r.timed_out = 1'b1;
							r.addr = tbl_addr[i];
							r.dtype = tbl_type[i];
							r.version = tbl_version[i];
							r.checkin = tbl_checkin[i];
							made.push_back(r);
						end
						tbl_attempts[i] = 8'd0;
					end else if (tbl_attempts[i] > 8'd1) begin
						tbl_attempts[i] = tbl_attempts[i] - 8'd1;
						if (tbl_checkin[i] != 16'd0)
							tbl_checkin[i] = tbl_checkin[i] - 16'd1;
					end
				end
				if (made.size() == 0) begin
					r = '0;
					made.push_back(r);
				end
			end
			default: begin
				made.push_back(r);
			end
		endcase
		for (int i = 0; i < ENTRIES; i++) begin
			if (tbl_attempts[i] != 8'd0) begin
				if (tbl_type[i] != TYPE_NONE)
					pend++;
				else
					noup++;
			end
		end
		foreach (made[k]) begin
			r = made[k];
			r.pending = (pend > 7) ? 3'd7 : pend[2:0];
			r.noupdate = (noup > 7) ? 3'd7 : noup[2:0];
			r.last = (k == made.size() - 1);
			replies_due.push_back(r);
		end
	endtask

	task automatic note_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: result %0d: %s is %h, expected %h", $time, replies_checked,
			what, got, want);
		error_count++;
	endtask

	task automatic check_reply();
		reply_t want;
		if (replies_due.size() == 0) begin
			note_mismatch("unexpected result, addr_out", addr_out, '0);
		end else begin
			want = replies_due.pop_front();
			replies_checked++;
			if (want.timed_out)
				timeouts_seen++;
			if (status !== want.status)
				note_mismatch("status", 64'(status), 64'(want.status));
			if (found !== want.found)
				note_mismatch("found", 64'(found), 64'(want.found));
			if (addr_out !== want.addr)
				note_mismatch("addr_out", addr_out, want.addr);
			if (type_out !== want.dtype)
				note_mismatch("type_out", 64'(type_out), 64'(want.dtype));
			if (version_out !== want.version)
				note_mismatch("version_out", version_out, want.version);
			if (checkin_out !== want.checkin)
				note_mismatch("checkin_out", 64'(checkin_out), 64'(want.checkin));
			if (timed_out !== want.timed_out)
				note_mismatch("timed_out", 64'(timed_out), 64'(want.timed_out));
			if (pending_count !== want.pending)
				note_mismatch("pending_count", 64'(pending_count), 64'(want.pending));
			if (noupdate_count !== want.noupdate)
				note_mismatch("noupdate_count", 64'(noupdate_count),
					64'(want.noupdate));
			if (last !== want.last)
				note_mismatch("last", 64'(last), 64'(want.last));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready)
			check_reply();
	end

	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= hold_len;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic send_op(input logic [2:0] op, input logic [63:0] a,
			input logic [7:0] att, input logic [7:0] dt, input logic [63:0] ver,
			input logic [15:0] chk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		dev_addr <= a;
		new_attempts <= att;
		new_type <= dt;
		new_version <= ver;
		new_checkin <= chk;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
		apply_to_table(op, a, att, dt, ver, chk);
	endtask

	task automatic wait_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (replies_due.size() != 0);
	endtask

	task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct <= recv_pct;
	endtask

	task automatic refill_pool();
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = {$urandom, $urandom};
	endtask

	task automatic send_random_op();
		logic [2:0]  op;
		logic [63:0] a;
		logic [7:0]  att;
		logic [7:0]  dt;
		logic [63:0] ver;
		logic [15:0] chk;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 34)
			op = OP_INSERT;
		else if (roll < 42)
			op = OP_CANCEL;
		else if (roll < 57)
			op = OP_LOOKUP;
		else if (roll < 75)
			op = OP_COMPLETE;
		else if (roll < 96)
			op = OP_TICK;
		else
			op = 3'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO));
		if ($urandom_range(99) < 80)
			a = addr_pool[$urandom_range(POOL_SIZE - 1)];
		else
			a = {$urandom, $urandom};
		roll = $urandom_range(99);
		if (roll < 8)
			att = 8'd0;
		else if (roll < 70)
			att = 8'($urandom_range(3, 1));
		else if (roll < 88)
			att = 8'($urandom_range(12, 4));
		else if (roll < 94)
			att = 8'hFF;
		else
			att = 8'($urandom);
		if ($urandom_range(99) < 25)
			dt = TYPE_NONE;
		else
			dt = 8'($urandom_range(255, 1));
		ver = {$urandom, $urandom};
		roll = $urandom_range(99);
		if (roll < 20)
			chk = 16'd0;
		else if (roll < 50)
			chk = 16'($urandom_range(3, 1));
		else
			chk = 16'($urandom);
		send_op(op, a, att, dt, ver, chk);
	endtask

	task automatic test_directed_cases();
		logic [63:0] dev [5];
		logic [63:0] spare;
		logic [63:0] stray;
		dev[0] = 64'h8000_0000_0000_0000;
		dev[1] = 64'h0000_0000_0000_0001;
		dev[2] = 64'h0123_4567_89AB_CDEF;
		dev[3] = 64'hFEDC_BA98_7654_3210;
		dev[4] = 64'h7FFF_FFFF_FFFF_FFFE;
		spare = 64'h5555_5555_5555_5555;
		stray = 64'hAAAA_AAAA_AAAA_AAAA;
		set_idling(30, 71);
		// Address zero is already the last acknowledged one after reset.
		send_op(OP_COMPLETE, '0, '0, '0, '0, '0);
		send_op(OP_LOOKUP, '0, '0, '0, '0, '0);
		send_op(OP_INSERT, '1, 8'hFF, 8'hFF, '1, 16'hFFFF);
		send_op(OP_LOOKUP, '1, '0, '0, '0, '0);
		send_op(OP_INSERT, '1, 8'd1, 8'h5A, 64'h0123_4567_89AB_CDEF, 16'd0);
		// An insert with no attempts leaves the entry free.
		send_op(OP_INSERT, spare, 8'd0, 8'h11, spare, 16'd9);
		send_op(OP_LOOKUP, spare, '0, '0, '0, '0);
		for (int i = 0; i < 5; i++)
			send_op(OP_INSERT, dev[i], 8'd1, 8'(i + 1), {$urandom, $urandom}, 16'(i));
		send_op(OP_INSERT, stray, 8'd4, 8'd2, '0, 16'd1);
		send_op(OP_INSERT, dev[1], 8'd1, 8'h33, '1, 16'd5);
		// Every entry times out on the same tick.
		send_op(OP_TICK, '0, '0, '0, '0, '0);
		send_op(OP_INSERT, dev[0], 8'd1, TYPE_NONE, '1, 16'd3);
		send_op(OP_INSERT, dev[1], 8'd3, 8'd7, 64'hDEAD_BEEF_0000_0001, 16'd0);
		send_op(OP_TICK, '0, '0, '0, '0, '0);
		send_op(OP_COMPLETE, dev[1], '0, '0, '0, '0);
		send_op(OP_COMPLETE, dev[1], '0, '0, '0, '0);
		send_op(OP_COMPLETE, stray, '0, '0, '0, '0);
		send_op(OP_LOOKUP, dev[1], '0, '0, '0, '0);
		send_op(OP_COMPLETE, '0, '0, '0, '0, '0);
		send_op(OP_INSERT, dev[2], 8'd2, 8'd1, '1, 16'd2);
		send_op(OP_CANCEL, dev[2], '0, '0, '0, '0);
		send_op(OP_RESERVED_LO, '1, '1, '1, '1, '1);
		send_op(OP_RESERVED_HI, '0, '0, '0, '0, '0);
		wait_until_drained();
	endtask

	task automatic test_random_traffic(input int unsigned send_pct,
			input int unsigned recv_pct, input int unsigned count);
		set_idling(send_pct, recv_pct);
		refill_pool();
		repeat (count) send_random_op();
		wait_until_drained();
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		refill_pool();
		hold_len <= HOLD_CYCLES;
		hold_token <= hold_token + 1;
		repeat (30) send_random_op();
		wait_until_drained();
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_addr[i] = '0;
			tbl_attempts[i] = '0;
			tbl_type[i] = '0;
			tbl_version[i] = '0;
			tbl_checkin[i] = '0;
		end
		last_acked = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_traffic(30, 71, 80);
		test_random_traffic(71, 30, 80);
		test_random_traffic(0, 0, 60);
		test_backpressure();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (replies_due.size() != 0)
			note_mismatch("results never delivered", 64'(replies_due.size()), '0);
		$display("Sent %0d operations and checked %0d results, %0d of them timeouts,",
			items_sent, replies_checked, timeouts_seen);
		$display("with idling on either side, none at all, and a %0d-cycle result stall.",
			HOLD_CYCLES);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
